/* hdl/gsft_pkg.sv */
// ----------------------------------------------------------------------------
// gsft_pkg
// Shared types, register indexes and saturation helpers for the splat frame
// transform.
// ----------------------------------------------------------------------------
`default_nettype none

package gsft_pkg;

  localparam int unsigned RowW    = 48;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [RowW-1:0] RowTopRst = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] RowMidRst = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] RowLowRst = 48'h0000_0000_4000;

  typedef enum logic [CfgIdxW-1:0] {
    RegRowTop = 2'd0,
    RegRowMid = 2'd1,
    RegRowLow = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [15:0] new_rot_x;
    logic signed [15:0] new_rot_y;
    logic signed [15:0] new_rot_z;
    logic signed [15:0] new_rot_w;
    logic signed [31:0] new_scale_x;
    logic signed [31:0] new_scale_y;
    logic signed [31:0] new_scale_z;
    logic               bad_matrix;
  } out_word_t;

  // alignment quaternion handed from the sequencer to the datapath
  typedef struct packed {
    logic               done;
    logic               bad;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] aw;
  } align_t;

  // signed q2.14 entry of a row, column 0 in the high bits
  function automatic logic signed [15:0] mat_entry(input logic [RowW-1:0] row,
                                                    input logic [1:0] col);
    logic signed [15:0] e;
    case (col)
      2'd0:    e = row[47:32];
      2'd1:    e = row[31:16];
      default: e = row[15:0];
    endcase
    return e;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -52'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
    logic signed [15:0] r;
    if (v > 38'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -38'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/gaussian_splat_frame_transform_core.sv */
// ----------------------------------------------------------------------------
// gaussian_splat_frame_transform_core
// Re-expresses Gaussian splats in the frame of a configured 3x3 matrix.
// ----------------------------------------------------------------------------
// One splat word is taken per cycle unless the pipe is stalled or the
// alignment is not done, through a four-stage multiplier pipeline; a held
// output stalls the whole pipe. After reset and after every matrix write, the
// alignment quaternion is rebuilt by a sequencer (a setup state, 15
// square-root steps, a rounding state, 29 divider steps) and in_ready_o
// stays low until it is done; matrix writes are always taken.
`default_nettype none

module gaussian_splat_frame_transform_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire gsft_pkg::in_word_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output gsft_pkg::out_word_t               out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [gsft_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [gsft_pkg::RowW-1:0]    cfg_data_i
);

  logic [gsft_pkg::RowW-1:0] row_top_q, row_mid_q, row_low_q;
  logic                      cfg_wr;
  gsft_pkg::align_t          align;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_top_q <= gsft_pkg::RowTopRst;
      row_mid_q <= gsft_pkg::RowMidRst;
      row_low_q <= gsft_pkg::RowLowRst;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        gsft_pkg::RegRowTop: row_top_q <= cfg_data_i;
        gsft_pkg::RegRowMid: row_mid_q <= cfg_data_i;
        gsft_pkg::RegRowLow: row_low_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gsft_align u_align (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .row_top_i (row_top_q),
    .row_mid_i (row_mid_q),
    .row_low_i (row_low_q),
    .align_o   (align)
  );

  gsft_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .row_top_i   (row_top_q),
    .row_mid_i   (row_mid_q),
    .row_low_i   (row_low_q),
    .align_i     (align)
  );

endmodule

`default_nettype wire

/* hdl/gsft_align.sv */
// ----------------------------------------------------------------------------
// gsft_align
// Turns the configured matrix into the alignment quaternion: trace branch,
// bit-serial square root, then four restoring dividers in lockstep.
// ----------------------------------------------------------------------------
`default_nettype none

module gsft_align (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     restart_i,
  input  wire logic [gsft_pkg::RowW-1:0] row_top_i,
  input  wire logic [gsft_pkg::RowW-1:0] row_mid_i,
  input  wire logic [gsft_pkg::RowW-1:0] row_low_i,
  output gsft_pkg::align_t              align_o
);

  typedef enum logic [2:0] {
    StCalc, StSqrt, StFin, StDiv, StDone
  } state_e;

  typedef enum logic [1:0] {
    PartX = 2'd0, PartY = 2'd1, PartZ = 2'd2, PartW = 2'd3
  } part_e;

  localparam int unsigned NumW  = 29;
  localparam int unsigned DivSteps = NumW;

  state_e state_q, state_d;
  part_e  sel_q, sel_c;
  logic   bad_q, bad_d;
  logic [29:0] x_q, x_d, r_q, r_d, bit_q, bit_d;
  logic [15:0] big_q, big_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [NumW-1:0] num_q [4];
  logic [NumW-1:0] num_d [4];
  logic [15:0] rem_q [4];
  logic [15:0] rem_d [4];
  logic        neg_q [4];
  logic        neg_d [4];

  logic signed [15:0] m [9];
  logic signed [17:0] tr;
  logic signed [19:0] g;
  logic signed [16:0] dv [4];
  logic [29:0] sum_c;
  logic [15:0] big_c;
  logic [16:0] rem_sh [4];
  logic [16:0] dabs [4];
  logic signed [15:0] part [4];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      m[j]     = gsft_pkg::mat_entry(row_top_i, 2'(j));
      m[3 + j] = gsft_pkg::mat_entry(row_mid_i, 2'(j));
      m[6 + j] = gsft_pkg::mat_entry(row_low_i, 2'(j));
    end
    tr = 18'(m[0]) + 18'(m[4]) + 18'(m[8]);
    for (int i = 0; i < 4; i++) dv[i] = '0;
    if (tr > 0) begin
      sel_c = PartW;
      g     = 20'sd16384 + 20'(tr);
      dv[0] = 17'(m[7]) - 17'(m[5]);
      dv[1] = 17'(m[2]) - 17'(m[6]);
      dv[2] = 17'(m[3]) - 17'(m[1]);
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel_c = PartX;
      g     = 20'sd16384 + 20'(m[0]) - 20'(m[4]) - 20'(m[8]);
      dv[3] = 17'(m[7]) - 17'(m[5]);
      dv[1] = 17'(m[1]) + 17'(m[3]);
      dv[2] = 17'(m[2]) + 17'(m[6]);
    end else if (m[4] > m[8]) begin
      sel_c = PartY;
      g     = 20'sd16384 + 20'(m[4]) - 20'(m[0]) - 20'(m[8]);
      dv[3] = 17'(m[2]) - 17'(m[6]);
      dv[0] = 17'(m[1]) + 17'(m[3]);
      dv[2] = 17'(m[5]) + 17'(m[7]);
    end else begin
      sel_c = PartZ;
      g     = 20'sd16384 + 20'(m[8]) - 20'(m[0]) - 20'(m[4]);
      dv[3] = 17'(m[3]) - 17'(m[1]);
      dv[0] = 17'(m[2]) + 17'(m[6]);
      dv[1] = 17'(m[5]) + 17'(m[7]);
    end
  end

  assign sum_c = r_q + bit_q;
  // round the floor root up when the remainder exceeds it
  assign big_c = (x_q > r_q) ? 16'(r_q + 30'd1) : r_q[15:0];

  always_comb begin
    state_d = state_q;
    bad_d   = bad_q;
    x_d     = x_q;
    r_d     = r_q;
    bit_d   = bit_q;
    big_d   = big_q;
    cnt_d   = cnt_q;
    for (int i = 0; i < 4; i++) begin
      num_d[i]  = num_q[i];
      rem_d[i]  = rem_q[i];
      neg_d[i]  = neg_q[i];
      dabs[i]   = dv[i][16] ? 17'(-dv[i]) : 17'(dv[i]);
      rem_sh[i] = {rem_q[i], num_q[i][NumW-1]};
    end
    case (state_q)
      StCalc: begin
        bad_d = (g <= 0);
        x_d   = {g[17:0], 12'd0};
        r_d   = '0;
        bit_d = 30'd1 << 28;
        for (int i = 0; i < 4; i++) begin
          neg_d[i] = dv[i][16];
          num_d[i] = {dabs[i], 12'd0};
        end
        state_d = (g <= 0) ? StDone : StSqrt;
      end
      StSqrt: begin
        if (x_q >= sum_c) begin
          x_d = x_q - sum_c;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 30'd1) state_d = StFin;
      end
      StFin: begin
        big_d = big_c;
        cnt_d = '0;
        for (int i = 0; i < 4; i++) begin
          num_d[i] = num_q[i] + NumW'(big_c >> 1);
          rem_d[i] = '0;
        end
        state_d = StDiv;
      end
      StDiv: begin
        for (int i = 0; i < 4; i++) begin
          if (rem_sh[i] >= {1'b0, big_q}) begin
            rem_d[i] = 16'(rem_sh[i] - {1'b0, big_q});
            num_d[i] = {num_q[i][NumW-2:0], 1'b1};
          end else begin
            rem_d[i] = rem_sh[i][15:0];
            num_d[i] = {num_q[i][NumW-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) state_d = StDone;
      end
      StDone: ;
      default: state_d = StCalc;
    endcase
    if (restart_i) state_d = StCalc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCalc;
      bad_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      bad_q   <= bad_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StCalc) sel_q <= sel_c;
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    big_q <= big_d;
    for (int i = 0; i < 4; i++) begin
      num_q[i] <= num_d[i];
      rem_q[i] <= rem_d[i];
      neg_q[i] <= neg_d[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sel_q == part_e'(i)) begin
        part[i] = big_q;
      end else if (!neg_q[i]) begin
        part[i] = (num_q[i] > NumW'(32767)) ? 16'sh7FFF : num_q[i][15:0];
      end else begin
        part[i] = (num_q[i] > NumW'(32768)) ? 16'sh8000 : 16'(~num_q[i][15:0] + 16'd1);
      end
    end
  end

  assign align_o.done = (state_q == StDone);
  assign align_o.bad  = bad_q;
  assign align_o.ax   = part[0];
  assign align_o.ay   = part[1];
  assign align_o.az   = part[2];
  assign align_o.aw   = part[3];

endmodule

`default_nettype wire

/* hdl/gsft_pipe.sv */
// ----------------------------------------------------------------------------
// gsft_pipe
// Four-stage datapath: products, sums and the first quaternion product,
// second quaternion products, final sums into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsft_pipe (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire gsft_pkg::in_word_t        in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output gsft_pkg::out_word_t            out_data_o,
  input  wire logic [gsft_pkg::RowW-1:0] row_top_i,
  input  wire logic [gsft_pkg::RowW-1:0] row_mid_i,
  input  wire logic [gsft_pkg::RowW-1:0] row_low_i,
  input  wire gsft_pkg::align_t          align_i
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [15:0] m [3][3];
  logic signed [17:0] am [3][3];
  logic signed [31:0] p [3];
  logic signed [31:0] s [3];
  logic signed [15:0] q [4];
  logic signed [15:0] a [4];

  logic signed [47:0] pp_q [3][3];
  logic signed [49:0] sp_q [3][3];
  logic signed [31:0] qa_q [4][4];
  logic signed [15:0] q1_q [4];
  logic signed [15:0] q2_q [4];
  logic signed [15:0] q3_q [4];
  logic               bad1_q, bad2_q, bad3_q;

  logic signed [31:0] pos2_q [3];
  logic signed [31:0] scl2_q [3];
  logic signed [31:0] pos3_q [3];
  logic signed [31:0] scl3_q [3];
  logic signed [19:0] h2_q [4];
  logic signed [35:0] ah_q [4][4];

  logic signed [49:0] psum [3];
  logic signed [51:0] pr   [3];
  logic signed [50:0] ssum [3];
  logic signed [51:0] sr   [3];
  logic signed [33:0] hs   [4];
  logic signed [33:0] hr   [4];
  logic signed [37:0] ts   [4];
  logic signed [37:0] tr   [4];
  gsft_pkg::out_word_t out_d, out_q;

  // whole pipe moves unless the output word is held
  assign en         = !v4_q || out_ready_i;
  assign in_ready_o = en && align_i.done;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      m[0][j] = gsft_pkg::mat_entry(row_top_i, 2'(j));
      m[1][j] = gsft_pkg::mat_entry(row_mid_i, 2'(j));
      m[2][j] = gsft_pkg::mat_entry(row_low_i, 2'(j));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        am[i][j] = m[i][j][15] ? 18'(-18'(m[i][j])) : 18'(m[i][j]);
      end
    end
    p[0] = in_data_i.pos_x;   p[1] = in_data_i.pos_y;   p[2] = in_data_i.pos_z;
    s[0] = in_data_i.scale_x; s[1] = in_data_i.scale_y; s[2] = in_data_i.scale_z;
    q[0] = in_data_i.rot_x;   q[1] = in_data_i.rot_y;
    q[2] = in_data_i.rot_z;   q[3] = in_data_i.rot_w;
    a[0] = align_i.ax; a[1] = align_i.ay; a[2] = align_i.az; a[3] = align_i.aw;
  end

  // stage 2 sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = 50'(pp_q[i][0]) + 50'(pp_q[i][1]) + 50'(pp_q[i][2]);
      ssum[i] = 51'(sp_q[i][0]) + 51'(sp_q[i][1]) + 51'(sp_q[i][2]);
      pr[i]   = 52'((psum[i] + 50'sd8192) >>> 14);
      sr[i]   = 52'((ssum[i] + 51'sd8192) >>> 14);
    end
    // q * conj(a), products qa[k][l] = q[k]*a[l]
    hs[0] = -34'(qa_q[3][0]) + 34'(qa_q[0][3]) - 34'(qa_q[1][2]) + 34'(qa_q[2][1]);
    hs[1] = -34'(qa_q[3][1]) + 34'(qa_q[0][2]) + 34'(qa_q[1][3]) - 34'(qa_q[2][0]);
    hs[2] = -34'(qa_q[3][2]) - 34'(qa_q[0][1]) + 34'(qa_q[1][0]) + 34'(qa_q[2][3]);
    hs[3] =  34'(qa_q[3][3]) + 34'(qa_q[0][0]) + 34'(qa_q[1][1]) + 34'(qa_q[2][2]);
    for (int k = 0; k < 4; k++) hr[k] = (hs[k] + 34'sd8192) >>> 14;
  end

  // stage 4 sums, products ah[k][l] = a[k]*h[l]
  always_comb begin
    ts[0] = 38'(ah_q[3][0]) + 38'(ah_q[0][3]) + 38'(ah_q[1][2]) - 38'(ah_q[2][1]);
    ts[1] = 38'(ah_q[3][1]) - 38'(ah_q[0][2]) + 38'(ah_q[1][3]) + 38'(ah_q[2][0]);
    ts[2] = 38'(ah_q[3][2]) + 38'(ah_q[0][1]) - 38'(ah_q[1][0]) + 38'(ah_q[2][3]);
    ts[3] = 38'(ah_q[3][3]) - 38'(ah_q[0][0]) - 38'(ah_q[1][1]) - 38'(ah_q[2][2]);
    for (int k = 0; k < 4; k++) tr[k] = (ts[k] + 38'sd8192) >>> 14;

    out_d.new_pos_x   = pos3_q[0];
    out_d.new_pos_y   = pos3_q[1];
    out_d.new_pos_z   = pos3_q[2];
    out_d.new_scale_x = scl3_q[0];
    out_d.new_scale_y = scl3_q[1];
    out_d.new_scale_z = scl3_q[2];
    out_d.bad_matrix  = bad3_q;
    if (bad3_q) begin
      out_d.new_rot_x = q3_q[0];
      out_d.new_rot_y = q3_q[1];
      out_d.new_rot_z = q3_q[2];
      out_d.new_rot_w = q3_q[3];
    end else begin
      out_d.new_rot_x = gsft_pkg::sat16(tr[0]);
      out_d.new_rot_y = gsft_pkg::sat16(tr[1]);
      out_d.new_rot_z = gsft_pkg::sat16(tr[2]);
      out_d.new_rot_w = gsft_pkg::sat16(tr[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i && align_i.done;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[i][j] <= m[i][j] * p[j];
          sp_q[i][j] <= am[i][j] * s[j];
        end
      end
      for (int k = 0; k < 4; k++) begin
        for (int l = 0; l < 4; l++) qa_q[k][l] <= q[k] * a[l];
        q1_q[k] <= q[k];
        q2_q[k] <= q1_q[k];
        q3_q[k] <= q2_q[k];
        h2_q[k] <= hr[k][19:0];
        for (int l = 0; l < 4; l++) ah_q[k][l] <= a[k] * h2_q[l];
      end
      bad1_q <= align_i.bad;
      bad2_q <= bad1_q;
      bad3_q <= bad2_q;
      for (int i = 0; i < 3; i++) begin
        pos2_q[i] <= gsft_pkg::sat32(pr[i]);
        scl2_q[i] <= gsft_pkg::sat32(sr[i]);
        pos3_q[i] <= pos2_q[i];
        scl3_q[i] <= scl2_q[i];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/gsft_checker.sv */
// ----------------------------------------------------------------------------
// gsft_checker
// Port-level checks on the frame transform core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gsft_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire gsft_pkg::out_word_t out_data_o,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // no input while the output is blocked
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // a matrix write restarts the alignment sequencer
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input accepted before alignment rebuilt");

endmodule

bind gaussian_splat_frame_transform_core gsft_checker u_gsft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
